[sv/dsl_pkg.sv]
// shared types and constants for the styled dda line rasterizer
// no dependencies; imported by dsl_ctrl, dsl_datapath and the top level
package dsl_pkg;

    localparam int REG_W     = 6;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DOT_PERIOD          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_PERIOD         = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DASHDOT_DASH_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DASHDOT_GAP_END     = 2'd3;

    localparam logic [REG_W-1:0] DOT_PERIOD_RST          = 6'd2;
    localparam logic [REG_W-1:0] DASH_PERIOD_RST         = 6'd6;
    localparam logic [REG_W-1:0] DASHDOT_DASH_LENGTH_RST = 6'd10;
    localparam logic [REG_W-1:0] DASHDOT_GAP_END_RST     = 6'd15;

    // request kinds carried on tuser
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // line styles
    localparam logic [1:0] STYLE_SOLID   = 2'd0;
    localparam logic [1:0] STYLE_DOT     = 2'd1;
    localparam logic [1:0] STYLE_DASH    = 2'd2;
    localparam logic [1:0] STYLE_DASHDOT = 2'd3;

    typedef struct packed {
        logic load;
        logic step;
        logic iterate;
        logic finish;
    } dsl_cmd_t;

    typedef struct packed {
        logic out_valid;
    } dsl_status_t;

endpackage

[sv/dsl_ctrl.sv]
// controller for the styled dda line rasterizer: request acceptance and divide sequencing
// depends on dsl_pkg
module dsl_ctrl #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tuser,
    output logic                  s_tready,
    input  logic                  m_tready,
    input  dsl_pkg::dsl_status_t  status,
    output dsl_pkg::dsl_cmd_t     cmd
);
    import dsl_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 2);
    localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(FRAC_BITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] iter_reg, iter_next;
    logic             accept;

    // a request may enter while the output register drains in the same cycle
    assign s_tready = (state_reg == ST_IDLE) && (!status.out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next  = state_reg;
        iter_next   = iter_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.iterate = 1'b0;
        cmd.finish  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == ACT_START) begin
                        cmd.load   = 1'b1;
                        iter_next  = '0;
                        state_next = ST_DIV;
                    end else begin
                        cmd.step = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                cmd.iterate = 1'b1;
                iter_next   = iter_reg + 1'b1;
                if (iter_reg == ITER_LAST) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            iter_reg  <= '0;
        end else begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

endmodule

[sv/dsl_datapath.sv]
// datapath for the styled dda line rasterizer: setup, two restoring dividers,
// position walk, style patterns, config registers and the output register; depends on dsl_pkg
module dsl_datapath #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  dsl_pkg::dsl_cmd_t                 cmd,
    output dsl_pkg::dsl_status_t              status,
    input  logic                              cfg_we,
    input  logic [dsl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dsl_pkg::REG_W-1:0]         cfg_wdata,
    input  logic [COORD_BITS-1:0]             x_start,
    input  logic [COORD_BITS-1:0]             y_start,
    input  logic [COORD_BITS-1:0]             x_end,
    input  logic [COORD_BITS-1:0]             y_end,
    input  logic [1:0]                        style,
    input  logic                              m_tready,
    output logic                              out_valid,
    output logic signed [COORD_BITS:0]        pixel_x,
    output logic signed [COORD_BITS:0]        pixel_y,
    output logic                              draw,
    output logic                              color,
    output logic                              last
);
    import dsl_pkg::*;

    localparam int POS_W  = COORD_BITS + 2 + FRAC_BITS;
    localparam int INC_W  = FRAC_BITS + 2;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int REM_W  = COORD_BITS + 1;
    localparam int STEP_W = COORD_BITS + 1;
    localparam logic signed [POS_W-1:0] HALF = POS_W'(1) <<< (FRAC_BITS - 1);

    // config registers
    logic [REG_W-1:0] dot_period_reg, dash_period_reg, dd_dash_len_reg, dd_gap_end_reg;

    // line state
    logic                    line_active_reg, line_active_next;
    logic [STEP_W-1:0]       steps_reg, steps_next;
    logic [REG_W-1:0]        pat_reg, pat_next;
    logic [REG_W-1:0]        dd_cnt_reg, dd_cnt_next;
    logic                    dd_pend_reg, dd_pend_next;
    logic [1:0]              style_reg, style_next;
    logic                    out_valid_reg, out_valid_next;

    // walk and divide payload
    logic signed [POS_W-1:0] x_pos_reg, x_pos_next, y_pos_reg, y_pos_next;
    logic signed [INC_W-1:0] x_inc_reg, x_inc_next, y_inc_reg, y_inc_next;
    logic [COORD_BITS-1:0]   len_reg, len_next;
    logic [REM_W-1:0]        x_rem_reg, x_rem_next, y_rem_reg, y_rem_next;
    logic [Q_W-1:0]          x_q_reg, x_q_next, y_q_reg, y_q_next;
    logic                    x_neg_reg, x_neg_next, y_neg_reg, y_neg_next;
    logic                    x_zero_reg, x_zero_next, y_zero_reg, y_zero_next;

    // output payload
    logic signed [COORD_BITS:0] pixel_x_reg, pixel_x_next, pixel_y_reg, pixel_y_next;
    logic draw_reg, draw_next, color_reg, color_next, last_reg, last_next;

    // setup terms
    logic [COORD_BITS-1:0]   adx, ady, len;
    logic                    x_neg, y_neg, x_zero, y_zero;
    logic signed [POS_W-1:0] x_base, y_base;

    // divide step terms
    logic                    x_ge, y_ge;
    logic [REM_W-1:0]        x_rn, y_rn, len_ext;

    // style terms
    logic                    step_ok, st_draw, st_color;
    logic [REG_W-1:0]        pat_inc, period;

    assign adx    = (x_end > x_start) ? x_end - x_start : x_start - x_end;
    assign ady    = (y_end > y_start) ? y_end - y_start : y_start - y_end;
    assign len    = (adx > ady) ? adx : ady;
    assign x_neg  = x_end < x_start;
    assign y_neg  = y_end < y_start;
    assign x_zero = x_end == x_start;
    assign y_zero = y_end == y_start;
    assign x_base = $signed({2'b00, x_start, {FRAC_BITS{1'b0}}});
    assign y_base = $signed({2'b00, y_start, {FRAC_BITS{1'b0}}});

    assign len_ext = {1'b0, len_reg};
    assign x_ge    = x_rem_reg >= len_ext;
    assign y_ge    = y_rem_reg >= len_ext;
    assign x_rn    = x_ge ? x_rem_reg - len_ext : x_rem_reg;
    assign y_rn    = y_ge ? y_rem_reg - len_ext : y_rem_reg;

    assign step_ok = cmd.step && line_active_reg && (steps_reg != '0);
    assign pat_inc = pat_reg + 1'b1;
    assign period  = (style_reg == STYLE_DOT) ? dot_period_reg : dash_period_reg;

    // per-pixel style decision
    always_comb begin
        st_draw      = 1'b1;
        st_color     = 1'b1;
        pat_next     = pat_reg;
        dd_cnt_next  = dd_cnt_reg;
        dd_pend_next = dd_pend_reg;
        unique case (style_reg) inside
            STYLE_SOLID: begin
                st_draw  = 1'b1;
                st_color = 1'b1;
            end
            STYLE_DOT, STYLE_DASH: begin
                if (style_reg == STYLE_DOT) begin
                    st_draw  = pat_reg == '0;
                    st_color = pat_reg == '0;
                end else begin
                    st_draw  = 1'b1;
                    st_color = pat_reg != '0;
                end
                // a zero period keeps the index at zero
                pat_next = (pat_inc >= period) ? '0 : pat_inc;
            end
            default: begin
                if (dd_cnt_reg < dd_dash_len_reg) begin
                    st_draw     = 1'b1;
                    dd_cnt_next = dd_cnt_reg + 1'b1;
                end else if (dd_cnt_reg < dd_gap_end_reg) begin
                    st_draw     = 1'b0;
                    dd_cnt_next = dd_cnt_reg + 1'b1;
                end else if (dd_pend_reg) begin
                    st_draw      = 1'b1;
                    dd_cnt_next  = dd_dash_len_reg;
                    dd_pend_next = 1'b0;
                end else begin
                    st_draw      = 1'b0;
                    dd_pend_next = 1'b1;
                    dd_cnt_next  = '0;
                end
                st_color = st_draw;
            end
        endcase
    end

    always_comb begin
        line_active_next = line_active_reg;
        steps_next       = steps_reg;
        style_next       = style_reg;
        x_pos_next       = x_pos_reg;
        y_pos_next       = y_pos_reg;
        x_inc_next       = x_inc_reg;
        y_inc_next       = y_inc_reg;
        len_next         = len_reg;
        x_rem_next       = x_rem_reg;
        y_rem_next       = y_rem_reg;
        x_q_next         = x_q_reg;
        y_q_next         = y_q_reg;
        x_neg_next       = x_neg_reg;
        y_neg_next       = y_neg_reg;
        x_zero_next      = x_zero_reg;
        y_zero_next      = y_zero_reg;
        pixel_x_next     = pixel_x_reg;
        pixel_y_next     = pixel_y_reg;
        draw_next        = draw_reg;
        color_next       = color_reg;
        last_next        = last_reg;
        out_valid_next   = m_tready ? 1'b0 : out_valid_reg;

        if (cmd.load) begin
            line_active_next = 1'b1;
            style_next       = style;
            len_next         = len;
            x_rem_next       = {1'b0, adx};
            y_rem_next       = {1'b0, ady};
            x_q_next         = '0;
            y_q_next         = '0;
            x_neg_next       = x_neg;
            y_neg_next       = y_neg;
            x_zero_next      = x_zero;
            y_zero_next      = y_zero;
            x_pos_next       = x_zero ? x_base : (x_neg ? x_base - HALF : x_base + HALF);
            y_pos_next       = y_zero ? y_base : (y_neg ? y_base - HALF : y_base + HALF);
            // dash-dot drops the final pixel except on a zero-length line
            if (style == STYLE_DASHDOT) begin
                steps_next = (len == '0) ? STEP_W'(1) : {1'b0, len};
            end else begin
                steps_next = {1'b0, len} + 1'b1;
            end
        end

        if (cmd.iterate) begin
            x_rem_next = {x_rn[REM_W-2:0], 1'b0};
            y_rem_next = {y_rn[REM_W-2:0], 1'b0};
            x_q_next   = {x_q_reg[Q_W-2:0], x_ge};
            y_q_next   = {y_q_reg[Q_W-2:0], y_ge};
        end

        if (cmd.finish) begin
            x_inc_next = x_zero_reg ? '0 :
                         (x_neg_reg ? -$signed({1'b0, x_q_reg}) : $signed({1'b0, x_q_reg}));
            y_inc_next = y_zero_reg ? '0 :
                         (y_neg_reg ? -$signed({1'b0, y_q_reg}) : $signed({1'b0, y_q_reg}));
        end

        if (cmd.step && !step_ok) begin
            line_active_next = 1'b0;
        end

        if (step_ok) begin
            // floor is the arithmetic shift, kept to the pixel width
            pixel_x_next   = x_pos_reg[FRAC_BITS+COORD_BITS:FRAC_BITS];
            pixel_y_next   = y_pos_reg[FRAC_BITS+COORD_BITS:FRAC_BITS];
            draw_next      = st_draw;
            color_next     = st_color;
            last_next      = steps_reg == STEP_W'(1);
            out_valid_next = 1'b1;
            steps_next     = steps_reg - 1'b1;
            if (steps_reg == STEP_W'(1)) begin
                line_active_next = 1'b0;
            end
            x_pos_next = x_pos_reg + POS_W'(x_inc_reg);
            y_pos_next = y_pos_reg + POS_W'(y_inc_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_period_reg  <= DOT_PERIOD_RST;
            dash_period_reg <= DASH_PERIOD_RST;
            dd_dash_len_reg <= DASHDOT_DASH_LENGTH_RST;
            dd_gap_end_reg  <= DASHDOT_GAP_END_RST;
            line_active_reg <= 1'b0;
            steps_reg       <= '0;
            pat_reg         <= '0;
            dd_cnt_reg      <= '0;
            dd_pend_reg     <= 1'b1;
            style_reg       <= STYLE_SOLID;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_DOT_PERIOD:          dot_period_reg  <= cfg_wdata;
                    CFG_DASH_PERIOD:         dash_period_reg <= cfg_wdata;
                    CFG_DASHDOT_DASH_LENGTH: dd_dash_len_reg <= cfg_wdata;
                    CFG_DASHDOT_GAP_END:     dd_gap_end_reg  <= cfg_wdata;
                endcase
            end
            line_active_reg <= line_active_next;
            steps_reg       <= steps_next;
            style_reg       <= style_next;
            out_valid_reg   <= out_valid_next;
            if (cmd.load) begin
                pat_reg     <= '0;
                dd_cnt_reg  <= '0;
                dd_pend_reg <= 1'b1;
            end else if (step_ok) begin
                pat_reg     <= pat_next;
                dd_cnt_reg  <= dd_cnt_next;
                dd_pend_reg <= dd_pend_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        x_pos_reg   <= x_pos_next;
        y_pos_reg   <= y_pos_next;
        x_inc_reg   <= x_inc_next;
        y_inc_reg   <= y_inc_next;
        len_reg     <= len_next;
        x_rem_reg   <= x_rem_next;
        y_rem_reg   <= y_rem_next;
        x_q_reg     <= x_q_next;
        y_q_reg     <= y_q_next;
        x_neg_reg   <= x_neg_next;
        y_neg_reg   <= y_neg_next;
        x_zero_reg  <= x_zero_next;
        y_zero_reg  <= y_zero_next;
        pixel_x_reg <= pixel_x_next;
        pixel_y_reg <= pixel_y_next;
        draw_reg    <= draw_next;
        color_reg   <= color_next;
        last_reg    <= last_next;
    end

    assign status.out_valid = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign pixel_x          = pixel_x_reg;
    assign pixel_y          = pixel_y_reg;
    assign draw             = draw_reg;
    assign color            = color_reg;
    assign last             = last_reg;

endmodule

[sv/dda_styled_line_rasterizer_top.sv]
// styled dda line rasterizer, top level; depends on dsl_pkg, dsl_ctrl, dsl_datapath
// a step request gives its pixel in the cycle after acceptance; steps sustain one per cycle
// while the output is not stalled by m_tready; a start request holds the input off through the
// bit-per-cycle divide and the finish step, so the next request enters once the controller idles
// a start or a step with no active line gives no result
// reset (aresetn low, synchronous) drops any line, empties the output and restores register defaults
module dda_styled_line_rasterizer_top #(
    parameter int COORD_BITS = 10,
    parameter int FRAC_BITS  = 16,
    localparam int S_TDATA_W = ((4 * COORD_BITS + 2 + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 * (COORD_BITS + 1) + 2 + 7) / 8) * 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [dsl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dsl_pkg::REG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // x_start, y_start, x_end, y_end, style, zero fill
    input  logic [S_TDATA_W-1:0]          s_tdata,
    // action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pixel_x, pixel_y, draw, color, zero fill
    output logic [M_TDATA_W-1:0]          m_tdata,
    output logic                          m_tlast
);
    import dsl_pkg::*;

    localparam int C = COORD_BITS;

    dsl_cmd_t    cmd;
    dsl_status_t status;

    logic signed [C:0] pixel_x, pixel_y;
    logic              draw, color;

    dsl_ctrl #(
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dsl_datapath #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .x_start   (s_tdata[C-1:0]),
        .y_start   (s_tdata[2*C-1:C]),
        .x_end     (s_tdata[3*C-1:2*C]),
        .y_end     (s_tdata[4*C-1:3*C]),
        .style     (s_tdata[4*C+1:4*C]),
        .m_tready  (m_tready),
        .out_valid (m_tvalid),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .draw      (draw),
        .color     (color),
        .last      (m_tlast)
    );

    assign m_tdata = M_TDATA_W'({color, draw, pixel_y, pixel_x});

endmodule

[tb/dda_styled_line_rasterizer_top_tb.sv]
// self-checking testbench for the styled dda line rasterizer top level
// directed table then random lines under random valid/ready gaps; needs dsl_pkg and the rtl
`timescale 1ns / 100ps

module dda_styled_line_rasterizer_top_tb;
    import dsl_pkg::*;

    localparam int COORD_BITS     = 10;
    localparam int FRAC_BITS      = 16;
    localparam int S_W            = ((4 * COORD_BITS + 2 + 7) / 8) * 8;
    localparam int M_W            = ((2 * (COORD_BITS + 1) + 2 + 7) / 8) * 8;
    localparam int PIX_W          = COORD_BITS + 1;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int HALF_PIXEL     = 1 << (FRAC_BITS - 1);
    // divider setup plus margin
    localparam int DRAIN_CYCLES   = FRAC_BITS + 3 + 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 850;

    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic             draw;
        logic             color;
        logic             last;
    } pixel_t;

    typedef enum {ROW_START, ROW_STEP, ROW_CFG} row_kind_t;
    typedef enum {PIN_PREDICT, PIN_PIXEL, PIN_SILENT} pin_kind_t;

    typedef struct {
        row_kind_t        kind;
        int               xs, ys, xe, ye;
        logic [1:0]       style;
        int               count;
        pin_kind_t        pin;
        pixel_t           pinned;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [REG_W-1:0] reg_val;
    } row_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_W-1:0]       s_tdata;
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_W-1:0]       m_tdata;
    logic                 m_tlast;

    dda_styled_line_rasterizer_top #(
        .COORD_BITS(COORD_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // shadow registers and walker state of the rasterizer
    logic [REG_W-1:0]        dot_len, dash_len, dd_dash_len, dd_gap_end;
    logic                    line_on;
    logic signed [27:0]      x_pos, y_pos;
    logic signed [17:0]      x_inc, y_inc;
    logic [10:0]             steps_left;
    logic [5:0]              pattern_idx;
    logic [5:0]              dd_count;
    logic                    dd_dot_pending;
    logic [1:0]              line_style;

    pixel_t pixel_q[$];
    row_t   dir_rows[$];
    int     n_errors;
    int     req_count;
    int     quiet_cycles;
    int     calm_left;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    function automatic void setup_axis(input int a, input int b, input int len,
                                       output logic signed [27:0] pos,
                                       output logic signed [17:0] inc);
        int d;
        int mag;
        d   = b - a;
        mag = d < 0 ? -d : d;
        if (len == 0 || d == 0) begin
            inc = '0;
            pos = 28'(a * (1 << FRAC_BITS));
        end else begin
            mag = (mag << FRAC_BITS) / len;
            inc = 18'(d < 0 ? -mag : mag);
            pos = 28'(d < 0 ? a * (1 << FRAC_BITS) - HALF_PIXEL
                            : a * (1 << FRAC_BITS) + HALF_PIXEL);
        end
    endfunction

    // advance the walker by one request; returns 1 when a pixel comes out
    function automatic bit walk_line(input logic act, input logic [S_W-1:0] d,
                                     output pixel_t p);
        int xs, ys, xe, ye, adx, ady, len;
        logic signed [27:0] fx, fy;
        logic [REG_W-1:0]   period;
        p = '0;
        if (act == ACT_START) begin
            xs  = int'(d[9:0]);
            ys  = int'(d[19:10]);
            xe  = int'(d[29:20]);
            ye  = int'(d[39:30]);
            adx = xe > xs ? xe - xs : xs - xe;
            ady = ye > ys ? ye - ys : ys - ye;
            len = adx > ady ? adx : ady;
            line_style = d[41:40];
            setup_axis(xs, xe, len, x_pos, x_inc);
            setup_axis(ys, ye, len, y_pos, y_inc);
            if (line_style == STYLE_DASHDOT)
                steps_left = len == 0 ? 11'd1 : 11'(len);
            else
                steps_left = 11'(len + 1);
            pattern_idx    = '0;
            dd_count       = '0;
            dd_dot_pending = 1'b1;
            line_on        = 1'b1;
            return 1'b0;
        end
        if (!line_on || steps_left == 0) begin
            line_on = 1'b0;
            return 1'b0;
        end
        fx   = x_pos >>> FRAC_BITS;
        fy   = y_pos >>> FRAC_BITS;
        p.px = fx[PIX_W-1:0];
        p.py = fy[PIX_W-1:0];
        case (line_style)
            STYLE_SOLID: begin
                p.draw  = 1'b1;
                p.color = 1'b1;
            end
            STYLE_DOT, STYLE_DASH: begin
                period = line_style == STYLE_DOT ? dot_len : dash_len;
                if (line_style == STYLE_DOT) begin
                    p.draw  = pattern_idx == 0;
                    p.color = p.draw;
                end else begin
                    p.draw  = 1'b1;
                    p.color = pattern_idx != 0;
                end
                pattern_idx = pattern_idx + 6'd1;
                if (pattern_idx >= period)
                    pattern_idx = '0;
            end
            default: begin
                if (dd_count < dd_dash_len) begin
                    p.draw   = 1'b1;
                    dd_count = dd_count + 6'd1;
                end else if (dd_count < dd_gap_end) begin
                    dd_count = dd_count + 6'd1;
                end else if (dd_dot_pending) begin
                    p.draw         = 1'b1;
                    dd_count       = dd_dash_len;
                    dd_dot_pending = 1'b0;
                end else begin
                    dd_dot_pending = 1'b1;
                    dd_count       = '0;
                end
                p.color = p.draw;
            end
        endcase
        p.last     = steps_left == 1;
        steps_left = steps_left - 11'd1;
        if (steps_left == 0)
            line_on = 1'b0;
        x_pos = x_pos + 28'(x_inc);
        y_pos = y_pos + 28'(y_inc);
        return 1'b1;
    endfunction

    function automatic logic [S_W-1:0] pack_line(input int xs, input int ys, input int xe,
                                                 input int ye, input logic [1:0] style);
        logic [S_W-1:0] d;
        d        = '0;
        d[9:0]   = xs[9:0];
        d[19:10] = ys[9:0];
        d[29:20] = xe[9:0];
        d[39:30] = ye[9:0];
        d[41:40] = style;
        return d;
    endfunction

    function automatic pixel_t pix(input int x, input int y, input logic dr, input logic co,
                                   input logic la);
        pixel_t p;
        p.px    = x[PIX_W-1:0];
        p.py    = y[PIX_W-1:0];
        p.draw  = dr;
        p.color = co;
        p.last  = la;
        return p;
    endfunction

    function automatic row_t line_row(input int xs, input int ys, input int xe, input int ye,
                                      input logic [1:0] style);
        row_t r;
        r       = '{kind: ROW_START, pin: PIN_PREDICT, default: 0};
        r.kind  = ROW_START;
        r.xs    = xs;
        r.ys    = ys;
        r.xe    = xe;
        r.ye    = ye;
        r.style = style;
        r.count = 1;
        r.pin   = PIN_PREDICT;
        return r;
    endfunction

    function automatic row_t step_row(input int count, input pin_kind_t pin, input pixel_t p);
        row_t r;
        r        = '{kind: ROW_STEP, pin: PIN_PREDICT, default: 0};
        r.kind   = ROW_STEP;
        r.count  = count;
        r.pin    = pin;
        r.pinned = p;
        return r;
    endfunction

    function automatic row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
        row_t r;
        r         = '{kind: ROW_CFG, pin: PIN_SILENT, default: 0};
        r.kind    = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = v;
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(99);
        if (r < 2) begin
            calm_left = $urandom_range(30, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int pick_coord();
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return 0;
        if (r == 1)
            return COORD_MAX;
        return $urandom_range(COORD_MAX);
    endfunction

    function automatic logic [REG_W-1:0] pick_reg();
        int r;
        r = $urandom_range(19);
        if (r < 3)
            return 6'd1;
        if (r < 6)
            return 6'd63;
        // zero acts as a period of one
        if (r == 6)
            return 6'd0;
        return 6'($urandom_range(1, 63));
    endfunction

    // present one request and wait for its acceptance edge
    task automatic send_req(input logic act, input logic [S_W-1:0] d);
        int gap;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic issue(input logic act, input logic [S_W-1:0] d, input pin_kind_t pin,
                         input pixel_t pinned);
        pixel_t p;
        bit     got;
        send_req(act, d);
        got = walk_line(act, d, p);
        if (act == ACT_START || got)
            req_count++;
        case (pin)
            PIN_PREDICT: if (got) pixel_q.push_back(p);
            PIN_PIXEL:   pixel_q.push_back(pinned);
            default: ;
        endcase
    endtask

    // registers change only once the pipe has drained
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] v);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DOT_PERIOD:          dot_len     = v;
            CFG_DASH_PERIOD:         dash_len    = v;
            CFG_DASHDOT_DASH_LENGTH: dd_dash_len = v;
            default:                 dd_gap_end  = v;
        endcase
    endtask

    initial begin
        int n;
        m_tready = 1'b0;
        forever begin
            n = ($urandom_range(15) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
            @(negedge aclk) m_tready <= 1'b1;
            repeat (n - 1) @(negedge aclk);
            n = ($urandom_range(9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            @(negedge aclk) m_tready <= 1'b0;
            repeat (n - 1) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        pixel_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.px    = m_tdata[PIX_W-1:0];
            got.py    = m_tdata[2*PIX_W-1:PIX_W];
            got.draw  = m_tdata[2*PIX_W];
            got.color = m_tdata[2*PIX_W+1];
            got.last  = m_tlast;
            if (pixel_q.size() == 0) begin
                $error("pixel with no request pending: x %0d y %0d",
                       $signed(got.px), $signed(got.py));
                n_errors++;
            end else begin
                want = pixel_q.pop_front();
                if (got.px !== want.px) begin
                    $error("pixel_x expected %0d got %0d", $signed(want.px), $signed(got.px));
                    n_errors++;
                end
                if (got.py !== want.py) begin
                    $error("pixel_y expected %0d got %0d", $signed(want.py), $signed(got.py));
                    n_errors++;
                end
                if (got.draw !== want.draw) begin
                    $error("draw expected %0b got %0b", want.draw, got.draw);
                    n_errors++;
                end
                if (got.color !== want.color) begin
                    $error("color expected %0b got %0b", want.color, got.color);
                    n_errors++;
                end
                if (got.last !== want.last) begin
                    $error("last expected %0b got %0b", want.last, got.last);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        row_t   r;
        int     xs, ys, xe, ye, adx, ady, len, npix, nsteps, roll, target, next_cfg;
        logic [1:0] style;

        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tuser   = 1'b0;
        s_tdata   = '0;
        n_errors  = 0;
        req_count = 0;
        calm_left = 0;
        quiet_cycles = 0;

        dot_len        = DOT_PERIOD_RST;
        dash_len       = DASH_PERIOD_RST;
        dd_dash_len    = DASHDOT_DASH_LENGTH_RST;
        dd_gap_end     = DASHDOT_GAP_END_RST;
        line_on        = 1'b0;
        x_pos          = '0;
        y_pos          = '0;
        x_inc          = '0;
        y_inc          = '0;
        steps_left     = '0;
        pattern_idx    = '0;
        dd_count       = '0;
        dd_dot_pending = 1'b1;
        line_style     = STYLE_SOLID;

        // step with no line, then zero-length lines at both corners
        dir_rows.push_back(step_row(1, PIN_SILENT, '0));
        dir_rows.push_back(line_row(0, 0, 0, 0, STYLE_SOLID));
        dir_rows.push_back(step_row(1, PIN_PIXEL, pix(0, 0, 1, 1, 1)));
        dir_rows.push_back(step_row(1, PIN_SILENT, '0));
        dir_rows.push_back(line_row(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, STYLE_DASHDOT));
        dir_rows.push_back(step_row(1, PIN_PIXEL, pix(COORD_MAX, COORD_MAX, 1, 1, 1)));
        // full diagonals, each abandoned by the next start
        dir_rows.push_back(line_row(0, COORD_MAX, COORD_MAX, 0, STYLE_DOT));
        dir_rows.push_back(step_row(1, PIN_PIXEL, pix(0, COORD_MAX - 1, 1, 1, 0)));
        dir_rows.push_back(step_row(1, PIN_PREDICT, '0));
        dir_rows.push_back(line_row(COORD_MAX, 0, 0, COORD_MAX, STYLE_DASH));
        dir_rows.push_back(step_row(1, PIN_PIXEL, pix(COORD_MAX - 1, 0, 1, 0, 0)));
        // steep line with negative dx, black at both ends of the line
        dir_rows.push_back(line_row(5, 3, 1, 9, STYLE_DASH));
        dir_rows.push_back(step_row(7, PIN_PREDICT, '0));
        // register changed in the middle of a dotted line, down to a zero period
        dir_rows.push_back(cfg_row(CFG_DOT_PERIOD, 6'd3));
        dir_rows.push_back(line_row(10, 10, 14, 12, STYLE_DOT));
        dir_rows.push_back(step_row(2, PIN_PREDICT, '0));
        dir_rows.push_back(cfg_row(CFG_DOT_PERIOD, 6'd0));
        dir_rows.push_back(step_row(4, PIN_PREDICT, '0));
        // dash-dot gives one pixel fewer
        dir_rows.push_back(line_row(0, 0, 3, 0, STYLE_DASHDOT));
        dir_rows.push_back(step_row(4, PIN_PREDICT, '0));

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            r = dir_rows[i];
            case (r.kind)
                ROW_CFG:
                    write_reg(r.reg_idx, r.reg_val);
                ROW_START:
                    issue(ACT_START, pack_line(r.xs, r.ys, r.xe, r.ye, r.style), r.pin, r.pinned);
                default:
                    repeat (r.count) issue(ACT_STEP, '0, r.pin, r.pinned);
            endcase
        end

        target   = req_count + RANDOM_ITEMS;
        next_cfg = req_count;
        while (req_count < target) begin
            if (req_count >= next_cfg) begin
                write_reg(CFG_DOT_PERIOD, pick_reg());
                write_reg(CFG_DASH_PERIOD, pick_reg());
                write_reg(CFG_DASHDOT_DASH_LENGTH, pick_reg());
                write_reg(CFG_DASHDOT_GAP_END, pick_reg());
                next_cfg = req_count + $urandom_range(60, 140);
            end
            style = 2'($urandom_range(3));
            xs    = pick_coord();
            ys    = pick_coord();
            if ($urandom_range(59) == 0) begin
                xe = $urandom_range(COORD_MAX);
                ye = $urandom_range(COORD_MAX);
            end else begin
                xe = xs + $urandom_range(40) - 20;
                ye = ys + $urandom_range(40) - 20;
                xe = xe < 0 ? 0 : (xe > COORD_MAX ? COORD_MAX : xe);
                ye = ye < 0 ? 0 : (ye > COORD_MAX ? COORD_MAX : ye);
            end
            adx  = xe > xs ? xe - xs : xs - xe;
            ady  = ye > ys ? ye - ys : ys - ye;
            len  = adx > ady ? adx : ady;
            npix = style == STYLE_DASHDOT ? (len == 0 ? 1 : len) : len + 1;
            // stray steps between lines
            if ($urandom_range(19) == 0)
                repeat ($urandom_range(1, 3)) issue(ACT_STEP, 48'($urandom()), PIN_PREDICT, '0);
            issue(ACT_START, pack_line(xs, ys, xe, ye, style), PIN_PREDICT, '0);
            roll = $urandom_range(99);
            if (roll < 75)
                nsteps = npix;
            else if (roll < 88)
                nsteps = $urandom_range(npix - 1);
            else
                nsteps = npix + $urandom_range(1, 3);
            repeat (nsteps) issue(ACT_STEP, '0, PIN_PREDICT, '0);
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[filelist.f]
sv/dsl_pkg.sv
sv/dsl_ctrl.sv
sv/dsl_datapath.sv
sv/dda_styled_line_rasterizer_top.sv
tb/dda_styled_line_rasterizer_top_tb.sv
